// ===== src/pfmi_pkg.sv =====
`default_nettype none
package pfmi_pkg;
	localparam int ELEM_BITS = 12;
	localparam int MAX_DIM = 8;
	localparam int IDX_BITS = $clog2(MAX_DIM);
	localparam int ADDR_BITS = 2 * IDX_BITS;
	localparam int DIM_BITS = 4;
	localparam int CNT_BITS = $clog2(ELEM_BITS + 1);
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_DIMENSION = 1'b1;

	localparam logic [ELEM_BITS-1:0] MODULUS_RESET = ELEM_BITS'(7);
	localparam logic [DIM_BITS-1:0] DIMENSION_RESET = DIM_BITS'(4);

	typedef struct packed {
		logic [ELEM_BITS-1:0] elem;
		logic [IDX_BITS-1:0]  row;
		logic [IDX_BITS-1:0]  col;
		logic                 last;
	} load_beat_t;

	typedef struct packed {
		logic [ELEM_BITS-1:0] p;
		logic [IDX_BITS-1:0]  last_idx;
	} field_cfg_t;
endpackage
`default_nettype wire

// ===== src/pfmi_div.sv =====
`default_nettype none
module pfmi_div import pfmi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [ELEM_BITS-1:0] num,
	input  wire logic [ELEM_BITS-1:0] den,
	output logic                      done,
	output logic [ELEM_BITS-1:0]      quot,
	output logic [ELEM_BITS-1:0]      rem
);
	logic [ELEM_BITS-1:0] num_q, den_q, quot_q, rem_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q, done_q;
	logic [ELEM_BITS:0]   trial, diff;

	always_comb begin
		trial = {rem_q, num_q[ELEM_BITS-1]};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(ELEM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (!diff[ELEM_BITS]) begin
				rem_q  <= diff[ELEM_BITS-1:0];
				quot_q <= {quot_q[ELEM_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= trial[ELEM_BITS-1:0];
				quot_q <= {quot_q[ELEM_BITS-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

// ===== src/pfmi_mulmod.sv =====
`default_nettype none
module pfmi_mulmod import pfmi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [ELEM_BITS-1:0] a,
	input  wire logic [ELEM_BITS-1:0] b,
	input  wire logic [ELEM_BITS-1:0] p,
	output logic                      done,
	output logic [ELEM_BITS-1:0]      res
);
	logic [ELEM_BITS-1:0] a_q, b_q, p_q, r_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 busy_q, done_q;
	logic [ELEM_BITS:0]   dbl, dbl_r, sum, sum_r;

	// shift-add, most significant multiplier bit first, reduced every step
	always_comb begin
		dbl   = {r_q, 1'b0};
		dbl_r = (dbl >= {1'b0, p_q}) ? dbl - {1'b0, p_q} : dbl;
		sum   = dbl_r + (b_q[ELEM_BITS-1] ? {1'b0, a_q} : '0);
		sum_r = (sum >= {1'b0, p_q}) ? sum - {1'b0, p_q} : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(ELEM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= p;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= b_q << 1;
			r_q <= sum_r[ELEM_BITS-1:0];
		end
	end

	assign done = done_q;
	assign res  = r_q;
endmodule
`default_nettype wire

// ===== src/pfmi_fifo.sv =====
`default_nettype none
module pfmi_fifo import pfmi_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire load_beat_t push_data,
	output logic            full,
	input  wire logic       pop,
	output load_beat_t      pop_data,
	output logic            not_empty
);
	load_beat_t mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	assign full      = cnt_q[1];
	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = mem_q[rd_q];
endmodule
`default_nettype wire

// ===== src/pfmi_front.sv =====
`default_nettype none
module pfmi_front import pfmi_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0]      prdata,
	input  wire logic [ELEM_BITS-1:0]  element,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       push,
	output load_beat_t                 push_data,
	input  wire logic                  full,
	output field_cfg_t                 cfg
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} front_state_t;

	front_state_t         state_q;
	logic [ELEM_BITS-1:0] modulus_q, red_q;
	logic [DIM_BITS-1:0]  dimension_q;
	logic [IDX_BITS-1:0]  row_q, col_q, last_idx;
	logic                 cfg_wr, accept, div_done, is_last;
	logic [ELEM_BITS-1:0] div_quot, div_rem;

	assign cfg_wr = psel && penable && pwrite;
	assign accept = in_valid && in_ready;

	always_comb begin
		if (dimension_q == '0) last_idx = '0;
		else if (dimension_q > DIM_BITS'(MAX_DIM)) last_idx = IDX_BITS'(MAX_DIM - 1);
		else last_idx = IDX_BITS'(dimension_q - 1'b1);
	end

	assign is_last = (row_q == last_idx) && (col_q == last_idx);

	pfmi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.num    (element),
		.den    (modulus_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			modulus_q   <= MODULUS_RESET;
			dimension_q <= DIMENSION_RESET;
			row_q       <= '0;
			col_q       <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					REG_MODULUS:   modulus_q <= pwdata[ELEM_BITS-1:0];
					REG_DIMENSION: dimension_q <= pwdata[DIM_BITS-1:0];
					default: ;
				endcase
				row_q <= '0;
				col_q <= '0;
			end
			unique case (state_q)
				F_IDLE: if (accept) state_q <= F_DIV;
				F_DIV:  if (div_done) state_q <= F_PUSH;
				F_PUSH: begin
					if (!full) begin
						state_q <= F_IDLE;
						if (col_q == last_idx) begin
							col_q <= '0;
							row_q <= (row_q == last_idx) ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (div_done) red_q <= (modulus_q < ELEM_BITS'(2)) ? '0 : div_rem;
	end

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !full;
	assign push_data = '{elem: red_q, row: row_q, col: col_q, last: is_last};
	assign cfg      = '{p: modulus_q, last_idx: last_idx};
	assign prdata   = (paddr[2] == REG_DIMENSION) ? PDATA_BITS'(dimension_q)
	                                              : PDATA_BITS'(modulus_q);
endmodule
`default_nettype wire

// ===== src/pfmi_back.sv =====
`default_nettype none
module pfmi_back import pfmi_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire field_cfg_t      cfg,
	input  wire load_beat_t      pop_data,
	input  wire logic            not_empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [ELEM_BITS-1:0] value,
	output logic                 status,
	output logic                 is_last
);
	typedef enum logic [20:0] {
		B_LOAD   = 21'h000001,
		B_INIT   = 21'h000002,
		B_PRD    = 21'h000004,
		B_PCHK   = 21'h000008,
		B_ESTART = 21'h000010,
		B_EDIV   = 21'h000020,
		B_EMUL   = 21'h000040,
		B_EUPD   = 21'h000080,
		B_EFIN   = 21'h000100,
		B_NRD    = 21'h000200,
		B_NMUL   = 21'h000400,
		B_NWT    = 21'h000800,
		B_JSEL   = 21'h001000,
		B_FGET   = 21'h002000,
		B_ERDI   = 21'h004000,
		B_ERDJ   = 21'h008000,
		B_EMM    = 21'h010000,
		B_EWT    = 21'h020000,
		B_ORD    = 21'h040000,
		B_OUT    = 21'h080000,
		B_SING   = 21'h100000
	} back_state_t;

	localparam int SW = ELEM_BITS + 2;
	localparam int PW = 2 * ELEM_BITS + 3;

	back_state_t state_q;
	logic [ELEM_BITS-1:0] wmem [2**ADDR_BITS];
	logic [ELEM_BITS-1:0] vmem [2**ADDR_BITS];
	logic [ELEM_BITS-1:0] rd_w_q, rd_v_q;
	logic [IDX_BITS-1:0]  i_q, j_q, k_q, lst;
	logic [ELEM_BITS-1:0] d_q, r0_q, pinv_q, f_q, bw_q, bv_q, aw_q, av_q, p;
	logic signed [SW-1:0] x_q, s_q, xa, t;
	logic signed [PW-1:0] prod_q;

	logic                 ren, we_w, we_v, mm_start, mm_w_done, mm_v_done, div_done;
	logic [ADDR_BITS-1:0] raddr, waddr;
	logic [ELEM_BITS-1:0] wd_w, wd_v, mm_a_w, mm_a_v, mm_b, mm_w_res, mm_v_res;
	logic [ELEM_BITS-1:0] div_quot, div_rem;
	logic [ELEM_BITS:0]   sub_w, sub_v;
	logic                 row_end, col_end;

	assign p   = cfg.p;
	assign lst = cfg.last_idx;
	assign row_end = (j_q == lst);
	assign col_end = (k_q == lst);

	pfmi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == B_ESTART),
		.num    (d_q),
		.den    (r0_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign mm_start = (state_q == B_NMUL) || (state_q == B_EMM);
	assign mm_a_w   = (state_q == B_NMUL) ? rd_w_q : bw_q;
	assign mm_a_v   = (state_q == B_NMUL) ? rd_v_q : bv_q;
	assign mm_b     = (state_q == B_NMUL) ? pinv_q : f_q;

	pfmi_mulmod u_mm_w (
		.clk (clk), .arst_n (arst_n), .start (mm_start),
		.a (mm_a_w), .b (mm_b), .p (p), .done (mm_w_done), .res (mm_w_res)
	);

	pfmi_mulmod u_mm_v (
		.clk (clk), .arst_n (arst_n), .start (mm_start),
		.a (mm_a_v), .b (mm_b), .p (p), .done (mm_v_done), .res (mm_v_res)
	);

	always_comb begin
		sub_w = {1'b0, aw_q} - {1'b0, mm_w_res};
		if (sub_w[ELEM_BITS]) sub_w = sub_w + {1'b0, p};
		sub_v = {1'b0, av_q} - {1'b0, mm_v_res};
		if (sub_v[ELEM_BITS]) sub_v = sub_v + {1'b0, p};
		t  = x_q - $signed(prod_q[SW-1:0]);
		xa = x_q[SW-1] ? x_q + $signed({2'b00, p}) : x_q;
	end

	always_comb begin
		ren   = 1'b0;
		raddr = {j_q, k_q};
		we_w  = 1'b0;
		we_v  = 1'b0;
		waddr = {j_q, k_q};
		wd_w  = mm_w_res;
		wd_v  = mm_v_res;
		pop   = 1'b0;
		unique case (state_q)
			B_LOAD: begin
				pop   = not_empty;
				we_w  = not_empty;
				waddr = {pop_data.row, pop_data.col};
				wd_w  = pop_data.elem;
			end
			B_INIT: begin
				we_v = 1'b1;
				wd_v = (j_q == k_q) ? ELEM_BITS'(1) : '0;
			end
			B_PRD: begin
				ren   = 1'b1;
				raddr = {i_q, i_q};
			end
			B_NRD, B_ERDI: begin
				ren   = 1'b1;
				raddr = {i_q, k_q};
			end
			B_NWT: begin
				we_w  = mm_w_done;
				we_v  = mm_v_done;
				waddr = {i_q, k_q};
			end
			B_JSEL: begin
				ren   = (j_q != i_q);
				raddr = {j_q, i_q};
			end
			B_ERDJ, B_ORD: ren = 1'b1;
			B_EWT: begin
				we_w = mm_w_done;
				we_v = mm_v_done;
				wd_w = sub_w[ELEM_BITS-1:0];
				wd_v = sub_v[ELEM_BITS-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_w) wmem[waddr] <= wd_w;
		if (we_v) vmem[waddr] <= wd_v;
		if (ren) begin
			rd_w_q <= wmem[raddr];
			rd_v_q <= vmem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			unique case (state_q)
				B_LOAD: begin
					if (not_empty && pop_data.last) begin
						j_q <= '0;
						k_q <= '0;
						state_q <= B_INIT;
					end
				end
				B_INIT: begin
					{j_q, k_q} <= {j_q, k_q} + 1'b1;
					if (&{j_q, k_q}) begin
						i_q <= '0;
						state_q <= B_PRD;
					end
				end
				B_PRD: state_q <= B_PCHK;
				B_PCHK: state_q <= (rd_w_q == '0) ? B_SING : B_ESTART;
				B_ESTART: state_q <= B_EDIV;
				B_EDIV: if (div_done) state_q <= B_EMUL;
				B_EMUL: state_q <= B_EUPD;
				B_EUPD: state_q <= (div_rem == '0) ? B_EFIN : B_ESTART;
				B_EFIN: begin
					k_q <= '0;
					state_q <= (d_q == ELEM_BITS'(1)) ? B_NRD : B_SING;
				end
				B_NRD: state_q <= B_NMUL;
				B_NMUL: state_q <= B_NWT;
				B_NWT: begin
					if (mm_w_done) begin
						if (col_end) begin
							j_q <= '0;
							state_q <= B_JSEL;
						end else begin
							k_q <= k_q + 1'b1;
							state_q <= B_NRD;
						end
					end
				end
				B_JSEL: begin
					if (j_q != i_q) begin
						state_q <= B_FGET;
					end else if (!row_end) begin
						j_q <= j_q + 1'b1;
					end else if (i_q == lst) begin
						j_q <= '0;
						k_q <= '0;
						state_q <= B_ORD;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= B_PRD;
					end
				end
				B_FGET: begin
					k_q <= '0;
					state_q <= B_ERDI;
				end
				B_ERDI: state_q <= B_ERDJ;
				B_ERDJ: state_q <= B_EMM;
				B_EMM: state_q <= B_EWT;
				B_EWT: begin
					if (mm_w_done) begin
						if (!col_end) begin
							k_q <= k_q + 1'b1;
							state_q <= B_ERDI;
						end else if (!row_end) begin
							j_q <= j_q + 1'b1;
							state_q <= B_JSEL;
						end else if (i_q == lst) begin
							j_q <= '0;
							k_q <= '0;
							state_q <= B_ORD;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= B_PRD;
						end
					end
				end
				B_ORD: state_q <= B_OUT;
				B_OUT: begin
					if (out_ready) begin
						if (row_end && col_end) begin
							state_q <= B_LOAD;
						end else begin
							if (col_end) begin
								k_q <= '0;
								j_q <= j_q + 1'b1;
							end else begin
								k_q <= k_q + 1'b1;
							end
							state_q <= B_ORD;
						end
					end
				end
				B_SING: if (out_ready) state_q <= B_LOAD;
				default: state_q <= B_LOAD;
			endcase
		end
	end

	// extended Euclid on (p, pivot), coefficient of the pivot kept signed
	always_ff @(posedge clk) begin
		case (state_q)
			B_PCHK: begin
				d_q  <= p;
				r0_q <= rd_w_q;
				x_q  <= '0;
				s_q  <= SW'(1);
			end
			B_EMUL: prod_q <= $signed({1'b0, div_quot}) * s_q;
			B_EUPD: begin
				d_q  <= r0_q;
				r0_q <= div_rem;
				x_q  <= s_q;
				s_q  <= t;
			end
			B_EFIN: pinv_q <= (xa >= $signed({2'b00, p})) ?
			                  xa[ELEM_BITS-1:0] - p : xa[ELEM_BITS-1:0];
			B_FGET: f_q <= rd_w_q;
			B_ERDJ: begin
				bw_q <= rd_w_q;
				bv_q <= rd_v_q;
			end
			B_EMM: begin
				aw_q <= rd_w_q;
				av_q <= rd_v_q;
			end
			default: ;
		endcase
	end

	assign out_valid = (state_q == B_OUT) || (state_q == B_SING);
	assign value     = (state_q == B_OUT) ? rd_v_q : '0;
	assign status    = (state_q == B_SING);
	assign is_last   = (state_q == B_SING) || (row_end && col_end);

`ifndef SYNTH
	a_sing_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> is_last && (value == '0))
		else $error("singular beat malformed");

	a_euclid_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_EFIN |-> (r0_q == '0) && $past(state_q == B_EUPD))
		else $error("Euclid finished with nonzero remainder");

	a_mm_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mm_w_done |-> (state_q == B_NWT || state_q == B_EWT) && mm_v_done)
		else $error("multiplier result with no waiting state");

	a_pop_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q == B_LOAD || state_q == B_INIT)
		else $error("queue popped outside loading");
`endif
endmodule
`default_nettype wire

// ===== src/prime_field_matrix_inverse_core.sv =====
`default_nettype none
// Matrix inverse over GF(p) by Gauss-Jordan elimination, no row swaps.
// Input channel (in_valid/in_ready, element): n*n elements row-major, each
// reduced mod p on entry by a 12-step divider; the front takes no new
// element until the last one has been pushed. Up to two reduced beats
// wait in a queue for the elimination engine. After the last beat: an
// identity sweep over all 64 entries of the inverse store, then per pivot
// an extended Euclid, a row normalize over each column and elimination of
// each element of every other row; both stores are updated by two serial
// modular multipliers in parallel.
// Output channel (out_valid/out_ready, value, status, is_last): n*n beats,
// is_last on the final one. A zero or non-invertible pivot gives one beat
// with status 1, value 0, is_last 1.
// A stalled receiver holds the engine; the queue and front keep taking
// elements of the next matrix until full.
// APB: modulus at 0x0, dimension at 0x4; a write restarts the load.
// Reset: modulus 7, dimension 4, load position cleared, engine idle.
module prime_field_matrix_inverse_core import pfmi_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [PADDR_BITS-1:0] paddr,
	input  wire logic [PDATA_BITS-1:0] pwdata,
	output logic [PDATA_BITS-1:0]      prdata,
	output logic                       pready,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [ELEM_BITS-1:0]  element,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [ELEM_BITS-1:0]       value,
	output logic                       status,
	output logic                       is_last
);
	field_cfg_t cfg;
	load_beat_t push_data, pop_data;
	logic       push, full, pop, not_empty;

	assign pready = 1'b1;

	pfmi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.element   (element),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.cfg       (cfg)
	);

	pfmi_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty)
	);

	pfmi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_data  (pop_data),
		.not_empty (not_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value),
		.status    (status),
		.is_last   (is_last)
	);
endmodule
`default_nettype wire
